@@ design/bgs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the charge percentage function of the battery gauge sequencer.
package bgs_pkg;

	localparam int VOLT_BITS_DEF = 15;
	localparam int ADC_W = 12;
	localparam int MV_W = 15;
	localparam int PCT_W = 7;
	localparam int GAIN_W = 16;
	localparam int OFS_W = 17;
	localparam int PROD_W = 29;
	localparam int CAL_W = 17;

	// Q4.12 calibration gains and Q5.12 offsets
	localparam logic [GAIN_W-1:0] STD_GAIN = 16'd34873;
	localparam logic [OFS_W-1:0] STD_OFS = 17'd86835;
	localparam logic [GAIN_W-1:0] MINI_GAIN = 16'd13455;
	localparam logic [OFS_W-1:0] MINI_OFS = 17'd28262;

	localparam logic [CAL_W-1:0] STD_MIN_MV = 17'd3800;
	localparam logic [CAL_W-1:0] STD_MAX_MV = 17'd7000;
	localparam logic [CAL_W-1:0] MINI_MIN_MV = 17'd1800;
	localparam logic [CAL_W-1:0] MINI_MAX_MV = 17'd3800;
	localparam logic [CAL_W-1:0] STD_LOW_MV = 17'd4800;
	localparam logic [CAL_W-1:0] STD_CRIT_MV = 17'd4000;
	localparam logic [CAL_W-1:0] MINI_LOW_MV = 17'd2400;
	localparam logic [CAL_W-1:0] MINI_CRIT_MV = 17'd2000;

	localparam logic [MV_W-1:0] STD_PCT_BASE = 15'd4000;
	localparam logic [MV_W-1:0] STD_PCT_SPAN = 15'd2000;
	localparam logic [MV_W-1:0] MINI_PCT_BASE = 15'd2000;
	localparam logic [MV_W-1:0] MINI_PCT_SPAN = 15'd1000;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	// 205/1024 approximates one fifth exactly for quotients below 500
	localparam logic [7:0] FIFTH_Q10 = 8'd205;

	typedef enum logic [1:0] {
		PH_DETECT,
		PH_FMT,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	typedef enum logic [2:0] {
		EV_ADC,
		EV_ERROR,
		EV_CRIT,
		EV_LOW,
		EV_UPDATE,
		EV_FORMAT
	} event_t;

	typedef enum logic [1:0] {
		FMT_UNKNOWN,
		FMT_STD,
		FMT_MINI
	} fmt_t;

	typedef struct packed {
		logic op;
		logic present;
		logic [ADC_W-1:0] adc;
		logic ok;
	} item_t;

	typedef struct packed {
		phase_t phase;
		fmt_t fmt;
		logic vok;
	} gauge_st_t;

	typedef struct packed {
		event_t ev;
		fmt_t fmt;
		logic [MV_W-1:0] mv;
		logic mv_ok;
		logic last;
	} res_t;

	function automatic logic [PCT_W-1:0] pct_of(fmt_t fmt, logic [MV_W-1:0] mv, logic ok);
		logic [MV_W-1:0] base;
		logic [MV_W-1:0] span;
		logic [MV_W-1:0] diff;
		logic [8:0] part;
		logic [16:0] prod;
		logic [PCT_W-1:0] pct;
		base = (fmt == FMT_MINI) ? MINI_PCT_BASE : STD_PCT_BASE;
		span = (fmt == FMT_MINI) ? MINI_PCT_SPAN : STD_PCT_SPAN;
		diff = mv - base;
		part = (fmt == FMT_MINI) ? diff[9:1] : diff[10:2];
		prod = 17'(part) * 17'(FIFTH_Q10);
		if (!ok || mv <= base) begin
			pct = '0;
		end else if (diff >= span) begin
			pct = PCT_FULL;
		end else begin
			pct = prod[16:10];
		end
		return pct;
	endfunction

endpackage

@@ design/bgs_pass.sv @@
`timescale 1ns / 1ps
// Per-word sequencing logic: calibration, range checks, thresholds and next state.
module bgs_pass #(
	parameter int VOLT_BITS = bgs_pkg::VOLT_BITS_DEF
) (
	input bgs_pkg::item_t item,
	input bgs_pkg::gauge_st_t st,
	input logic [VOLT_BITS-1:0] volt,
	input logic [bgs_pkg::MV_W-1:0] low_ovr,
	input logic [bgs_pkg::MV_W-1:0] crit_ovr,
	output bgs_pkg::gauge_st_t st_nxt,
	output logic [VOLT_BITS-1:0] volt_nxt,
	output logic no_res,
	output logic [1:0] n_res,
	output bgs_pkg::res_t res0,
	output bgs_pkg::res_t res1
);
	import bgs_pkg::*;

	localparam logic [CAL_W-1:0] VMAX = CAL_W'((1 << VOLT_BITS) - 1);

	logic mini;
	logic [GAIN_W-1:0] gain;
	logic [OFS_W-1:0] ofs;
	logic [PROD_W-1:0] sum;
	logic [CAL_W-1:0] raw;
	logic [CAL_W-1:0] v;
	logic [CAL_W-1:0] vmin;
	logic [CAL_W-1:0] vmax;
	logic [CAL_W-1:0] low;
	logic [CAL_W-1:0] crit;
	event_t ev0;

	always_comb begin
		mini = (st.phase == PH_MEAS) && (st.fmt == FMT_MINI);
		gain = mini ? MINI_GAIN : STD_GAIN;
		ofs = mini ? MINI_OFS : STD_OFS;
		sum = PROD_W'(item.adc) * PROD_W'(gain) + PROD_W'(ofs);
		raw = sum[PROD_W-1:12];
		v = (raw > VMAX) ? VMAX : raw;
		vmin = mini ? MINI_MIN_MV : STD_MIN_MV;
		vmax = mini ? MINI_MAX_MV : STD_MAX_MV;
		low = (low_ovr != '0) ? CAL_W'(low_ovr) : (mini ? MINI_LOW_MV : STD_LOW_MV);
		crit = (crit_ovr != '0) ? CAL_W'(crit_ovr) : (mini ? MINI_CRIT_MV : STD_CRIT_MV);

		st_nxt = st;
		volt_nxt = volt;
		n_res = 2'd0;
		ev0 = EV_ADC;

		case (st.phase)
			PH_DETECT: begin
				if (!item.op) begin
					st_nxt.fmt = FMT_UNKNOWN;
					n_res = 2'd1;
					if (item.present) begin
						st_nxt.phase = PH_FMT;
						ev0 = EV_ADC;
					end else begin
						ev0 = EV_ERROR;
					end
				end
			end
			PH_FMT: begin
				if (item.op) begin
					n_res = 2'd1;
					if (!item.ok) begin
						st_nxt.phase = PH_DETECT;
						ev0 = EV_ERROR;
					end else begin
						st_nxt.phase = PH_WAIT;
						st_nxt.fmt = (v > STD_MIN_MV && v < STD_MAX_MV) ? FMT_STD : FMT_MINI;
						ev0 = EV_FORMAT;
					end
				end
			end
			PH_WAIT: begin
				if (!item.op) begin
					st_nxt.phase = PH_MEAS;
					n_res = 2'd1;
					ev0 = EV_ADC;
				end
			end
			PH_MEAS: begin
				if (item.op) begin
					if (!item.ok || v < vmin || v > vmax) begin
						st_nxt.phase = PH_DETECT;
						st_nxt.vok = 1'b0;
						volt_nxt = '0;
						n_res = 2'd1;
						ev0 = EV_ERROR;
					end else begin
						st_nxt.phase = PH_WAIT;
						st_nxt.vok = 1'b1;
						volt_nxt = v[VOLT_BITS-1:0];
						if (v <= crit) begin
							n_res = 2'd2;
							ev0 = EV_CRIT;
						end else if (v <= low) begin
							n_res = 2'd2;
							ev0 = EV_LOW;
						end else begin
							n_res = 2'd1;
							ev0 = EV_UPDATE;
						end
					end
				end
			end
			default: begin
				n_res = 2'd0;
			end
		endcase

		no_res = (st.phase == PH_DETECT || st.phase == PH_WAIT) ? item.op : !item.op;

		res0.ev = ev0;
		res0.fmt = st_nxt.fmt;
		res0.mv = MV_W'(volt_nxt);
		res0.mv_ok = st_nxt.vok;
		res0.last = (n_res == 2'd1);
		res1.ev = EV_UPDATE;
		res1.fmt = st_nxt.fmt;
		res1.mv = MV_W'(volt_nxt);
		res1.mv_ok = st_nxt.vok;
		res1.last = 1'b1;
	end

endmodule

@@ design/battery_gauge_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Top level of the battery gauge sequencer: input register, sequencing state and result buffer.
// An input word is registered, then processed combinationally into a two-entry result buffer,
// which holds its first result. One word can be accepted every cycle while each word yields
// at most one result and the output side keeps up; a word that yields two results (a threshold
// event followed by update) holds the buffer until both are taken, as the output port delivers
// one result word per cycle while m_tready is high. Words that cause no result do not wait for
// buffer space. The low and critical thresholds are written through the APB port at byte
// addresses 0 and 4; the user must do so only while the unit is idle, as it is not enforced.
module battery_gauge_sequencer_unit #(
	parameter int VOLT_BITS = bgs_pkg::VOLT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata, // pack_present, adc_mv[11:0], adc_ok, zero padding
	input logic s_tuser, // op
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // pack_format[1:0], pack_mv[14:0], pack_mv_ok,
	                             // charge_percent[6:0], zero padding
	output logic [2:0] m_tuser, // event_res
	output logic m_tlast
);
	import bgs_pkg::*;

	localparam logic REG_LOW = 1'b0;
	localparam logic REG_CRIT = 1'b1;

	logic [MV_W-1:0] low_ovr_q;
	logic [MV_W-1:0] crit_ovr_q;
	logic cfg_wr;

	item_t item_s1;
	logic valid_s1;
	logic in_take;
	logic adv;

	gauge_st_t st_q;
	gauge_st_t st_nxt;
	logic [VOLT_BITS-1:0] volt_q;
	logic [VOLT_BITS-1:0] volt_nxt;
	logic no_res;
	logic [1:0] n_res;
	res_t res0;
	res_t res1;

	res_t buf_q [2];
	logic [1:0] cnt_q;
	logic out_take;
	logic space;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_CRIT) ? 32'(crit_ovr_q) : 32'(low_ovr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ovr_q <= '0;
			crit_ovr_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_LOW) begin
				low_ovr_q <= pwdata[MV_W-1:0];
			end else begin
				crit_ovr_q <= pwdata[MV_W-1:0];
			end
		end
	end

	// Input register
	assign out_take = m_tvalid && m_tready;
	assign space = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_take);
	assign adv = valid_s1 && (no_res || space);
	assign s_tready = !valid_s1 || adv;
	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op <= s_tuser;
			item_s1.present <= s_tdata[0];
			item_s1.adc <= s_tdata[12:1];
			item_s1.ok <= s_tdata[13];
		end
	end

	bgs_pass #(
		.VOLT_BITS(VOLT_BITS)
	) u_pass (
		.item(item_s1),
		.st(st_q),
		.volt(volt_q),
		.low_ovr(low_ovr_q),
		.crit_ovr(crit_ovr_q),
		.st_nxt(st_nxt),
		.volt_nxt(volt_nxt),
		.no_res(no_res),
		.n_res(n_res),
		.res0(res0),
		.res1(res1)
	);

	// Sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_DETECT, fmt: FMT_UNKNOWN, vok: 1'b0};
			volt_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
			volt_q <= volt_nxt;
		end
	end

	// Result buffer; new results are loaded only when it is empty after this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv && n_res != 2'd0) begin
			cnt_q <= n_res;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0) begin
			buf_q[0] <= res0;
			buf_q[1] <= res1;
		end else if (out_take) begin
			buf_q[0] <= buf_q[1];
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser = buf_q[0].ev;
	assign m_tlast = buf_q[0].last;
	assign m_tdata = {7'd0, pct_of(buf_q[0].fmt, buf_q[0].mv, buf_q[0].mv_ok),
		buf_q[0].mv_ok, buf_q[0].mv, buf_q[0].fmt};

	// A cleared measurement always leaves a zero voltage behind.
	a_volt_cleared : assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.vok |-> volt_q == '0)
		else $error("voltage register holds a value without a valid measurement");

	// The detect phase is only reached with no valid measurement held.
	a_detect_no_volt : assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_DETECT |-> !st_q.vok)
		else $error("valid measurement held in the detect phase");

	// With two results buffered, only the second closes the word.
	a_pair_last : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !buf_q[0].last && buf_q[1].last && buf_q[1].ev == EV_UPDATE)
		else $error("result pair has wrong last marking");

	// The buffer never holds more than two results.
	a_cnt_range : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

endmodule
